// ===== sv/rapq_pkg.sv =====
package rapq_pkg;

   // Store geometry and field widths.
   localparam int DEPTH   = 64;
   localparam int IDX_W   = 6;
   localparam int LEN_W   = 7;
   localparam int VALUE_W = 64;
   localparam int ADD_W   = 32;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);

   // Request kinds carried in the request's req_type field.
   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_DUMP  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        last_index;
      logic signed [ADD_W-1:0] add_value;
      logic [IDX_W-1:0]        query_index;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [IDX_W-1:0]          result_index;
      logic                      status;
      logic                      last_of_run;
   } rsp_item_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_FIRST,
      ST_ADD_NEXT,
      ST_WALK_START,
      ST_WALK,
      ST_DRAIN
   } ctrl_state_type;

   // Memory read address select.
   typedef enum logic [1:0] {
      RD_FIRST,
      RD_NEXT,
      RD_WALK
   } rd_sel_type;

   // Memory write address and data select.
   typedef enum logic {
      WR_FIRST,
      WR_NEXT
   } wr_sel_type;

   // Kind of response built by the datapath.
   typedef enum logic [1:0] {
      RSP_DONE_ADD,
      RSP_FLAG,
      RSP_CLEAR,
      RSP_WALK
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         mem_rd;
      rd_sel_type   rd_sel;
      logic         mem_wr;
      wr_sel_type   wr_sel;
      logic         walk_clr;
      logic         walk_step;
      logic         acc;
      logic         emit;
      rsp_kind_type rsp_kind;
      logic         last;
      logic         clear;
   } ctrl_cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         add_bad;
      logic         query_bad;
      logic         has_tail;
      logic         walk_end;
   } dp_status_type;

endpackage

// ===== sv/rapq_datapath.sv =====
module rapq_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  rapq_pkg::req_item_type req_item,
   input  logic                   csr_valid,
   input  logic [6:0]             csr_data,
   input  rapq_pkg::ctrl_cmd_type cmd,
   output rapq_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output rapq_pkg::rsp_item_type rsp_item
);
   import rapq_pkg::*;

   // Configuration and latched request.
   logic [LEN_W-1:0]    active_length_ff;
   logic [LEN_W-1:0]    len_eff_in;
   logic [LEN_W-1:0]    len_ff;
   req_item_type        req_ff;
   logic [VALUE_W-1:0]  value_ext;
   logic [IDX_W-1:0]    tail_idx;
   logic [LEN_W-1:0]    tail_wide;
   logic [IDX_W-1:0]    end_idx;

   // Store and its read port.
   logic [VALUE_W-1:0]  store_ff [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic                rd_hit_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic [VALUE_W-1:0]  entry;

   // Walk registers.
   logic [IDX_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]  sum_ff;
   logic [VALUE_W-1:0]  sum_in;

   // Response register.
   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff;
   rsp_item_type        rsp_item_in;

   // The length register is written whenever the channel offers data.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= LEN_RESET;
      end else if (csr_valid) begin
         active_length_ff <= csr_data;
      end
   end

   // Lengths above the depth act as the depth, and zero acts as one.
   always_comb begin
      if (active_length_ff > LEN_W'(DEPTH)) begin
         len_eff_in = LEN_W'(DEPTH);
      end else if (active_length_ff == '0) begin
         len_eff_in = LEN_W'(1);
      end else begin
         len_eff_in = active_length_ff;
      end
   end

   // Capture the request and the effective length when a transaction starts.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
         len_ff <= len_eff_in;
      end
   end

   assign value_ext = {{(VALUE_W-ADD_W){req_ff.add_value[ADD_W-1]}}, req_ff.add_value};
   assign tail_wide = {1'b0, req_ff.last_index} + LEN_W'(1);
   assign tail_idx  = tail_wide[IDX_W-1:0];
   assign end_idx   = (req_ff.req_type == REQ_QUERY) ? req_ff.query_index
                                                     : IDX_W'(len_ff - LEN_W'(1));

   // Checks that steer the controller.
   always_comb begin
      status.req_kind  = req_kind_type'(req_ff.req_type);
      status.add_bad   = (req_ff.first_index > req_ff.last_index) ||
                         ({1'b0, req_ff.last_index} >= len_ff);
      status.query_bad = ({1'b0, req_ff.query_index} >= len_ff);
      status.has_tail  = (tail_wide < len_ff);
      status.walk_end  = (pos_ff == end_idx);
   end

   // An entry never written since the last clear reads as zero.
   assign entry = rd_hit_ff ? rd_data_ff : '0;

   // Address and data selection for the store.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_FIRST: rd_addr = req_ff.first_index;
         RD_NEXT:  rd_addr = tail_idx;
         RD_WALK:  rd_addr = pos_ff;
         default:  rd_addr = pos_ff;
      endcase
      unique case (cmd.wr_sel)
         WR_FIRST: begin
            wr_addr = req_ff.first_index;
            wr_data = entry + value_ext;
         end
         WR_NEXT: begin
            wr_addr = tail_idx;
            wr_data = entry - value_ext;
         end
      endcase
   end

   // Store memory with one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= store_ff[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Written flags stand in for clearing the memory itself.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.mem_wr) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Walk position and running prefix sum.
   assign sum_in = sum_ff + entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (cmd.walk_clr) begin
            pos_ff <= '0;
         end else if (cmd.walk_step) begin
            pos_ff <= pos_ff + IDX_W'(1);
         end
         if (cmd.walk_clr) begin
            sum_ff <= '0;
         end else if (cmd.acc) begin
            sum_ff <= sum_in;
         end
      end
   end

   // Build the response for the requested kind.
   always_comb begin
      rsp_item_in = '0;
      unique case (cmd.rsp_kind)
         RSP_DONE_ADD: begin
            rsp_item_in.result_index = req_ff.first_index;
            rsp_item_in.last_of_run  = 1'b1;
         end
         RSP_FLAG: begin
            rsp_item_in.result_index = (req_ff.req_type == REQ_ADD) ? req_ff.first_index
                                                                    : req_ff.query_index;
            rsp_item_in.status       = 1'b1;
            rsp_item_in.last_of_run  = 1'b1;
         end
         RSP_CLEAR: begin
            rsp_item_in.last_of_run  = 1'b1;
         end
         RSP_WALK: begin
            rsp_item_in.result_value = sum_in;
            rsp_item_in.result_index = rd_idx_ff;
            rsp_item_in.last_of_run  = cmd.last;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sv/rapq_ctrl.sv =====
module rapq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  rapq_pkg::dp_status_type status,
   output rapq_pkg::ctrl_cmd_type  cmd
);
   import rapq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_sel   = RD_WALK;
      cmd.wr_sel   = WR_FIRST;
      cmd.rsp_kind = RSP_WALK;
      busy         = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (status.req_kind)
               REQ_ADD: begin
                  if (status.add_bad) begin
                     cmd.emit     = 1'b1;
                     cmd.rsp_kind = RSP_FLAG;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.rd_sel = RD_FIRST;
                     state_in   = ST_ADD_FIRST;
                  end
               end
               REQ_QUERY: begin
                  if (status.query_bad) begin
                     cmd.emit     = 1'b1;
                     cmd.rsp_kind = RSP_FLAG;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.walk_clr = 1'b1;
                     state_in     = ST_WALK_START;
                  end
               end
               REQ_DUMP: begin
                  cmd.walk_clr = 1'b1;
                  state_in     = ST_WALK_START;
               end
               REQ_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.emit     = 1'b1;
                  cmd.rsp_kind = RSP_CLEAR;
                  state_in     = ST_IDLE;
               end
            endcase
         end

         // Add the value at the first index; read the entry after the range if there is one, else report completion.
         ST_ADD_FIRST: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_FIRST;
            if (status.has_tail) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_ADD_NEXT;
            end else begin
               cmd.emit     = 1'b1;
               cmd.rsp_kind = RSP_DONE_ADD;
               state_in     = ST_IDLE;
            end
         end

         // Take the value from the entry after the range and report completion.
         ST_ADD_NEXT: begin
            cmd.mem_wr   = 1'b1;
            cmd.wr_sel   = WR_NEXT;
            cmd.emit     = 1'b1;
            cmd.rsp_kind = RSP_DONE_ADD;
            state_in     = ST_IDLE;
         end

         // Issue the first walk read.
         ST_WALK_START: begin
            cmd.mem_rd    = 1'b1;
            cmd.walk_step = 1'b1;
            state_in      = status.walk_end ? ST_DRAIN : ST_WALK;
         end

         // Accumulate the previous read while issuing the next one; a dump reports each sum.
         ST_WALK: begin
            cmd.acc       = 1'b1;
            cmd.emit      = (status.req_kind == REQ_DUMP);
            cmd.mem_rd    = 1'b1;
            cmd.walk_step = 1'b1;
            state_in      = status.walk_end ? ST_DRAIN : ST_WALK;
         end

         // Accumulate the final read and report it.
         ST_DRAIN: begin
            cmd.acc  = 1'b1;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/range_add_point_query_store.sv =====
// Range-add / point-query store over a 64-entry difference array of signed 64-bit
// values. A transaction is taken when start is high and busy is low; every result
// appears for one cycle with rsp_valid and cannot be held off by the receiver.
// A range add writes the first index and then, if there is a tail, the entry after
// the range; a flagged request or a clear answers from decode; a point query walks
// entries 0 to query_index and a dump walks the active length, streaming one result
// a cycle; the walk reads the store one entry a cycle. The length register accepts a
// write in any cycle, and a transaction uses the length in force when it is accepted.
module range_add_point_query_store (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rapq_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output rapq_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [6:0]             csr_data
);
   import rapq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The length register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   rapq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rapq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // An accepted transaction makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // A result only follows a cycle in which the block was busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result delivered without a transaction in flight");

   // A flagged result always ends its run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status) |-> rsp_item.last_of_run)
      else $error("flagged result does not end its run");

   // A dump streams without gaps until its last result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last_of_run) |=> rsp_valid)
      else $error("gap inside a result run");

endmodule
